// ===== rtl/core/double_ended_queue_with_search_defines.svh =====
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH

// same-cycle implication
`define DQS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqs check failed");

// next-cycle implication
`define DQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqs check failed");

`endif

// ===== rtl/core/dqs_pkg.sv =====
package dqs_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_WIDTH      = 64;
   localparam int TOL_WIDTH        = 32;
   localparam int ACTION_WIDTH     = 3;
   localparam int COUNT_OUT_WIDTH  = 7;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd4096;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_PEEK_FRONT = 3'd4,
      ACT_PEEK_BACK  = 3'd5,
      ACT_CLEAR      = 3'd6,
      ACT_SEARCH     = 3'd7
   } dqs_action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PEEK,
      ST_SEARCH,
      ST_DRAIN_READ,
      ST_DRAIN_CMP
   } dqs_state_type;

   typedef enum logic [1:0] {
      RD_FRONT,
      RD_BACK,
      RD_WALK
   } dqs_rd_sel_type;

   typedef struct packed {
      logic           load_req;
      logic           commit;
      logic           rd_en;
      dqs_rd_sel_type rd_sel;
      logic           walk_clear;
      logic           walk_step;
      logic           respond;
      logic           rsp_fail;
      logic           rsp_peek;
      logic           rsp_found;
   } dqs_cmd_type;

   typedef struct packed {
      dqs_action_type action;
      logic           empty;
      logic           full;
      logic           walk_last;
   } dqs_status_type;

endpackage

// ===== rtl/core/dqs_ctrl.sv =====
`include "double_ended_queue_with_search_defines.svh"

module dqs_ctrl
   import dqs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  dqs_status_type status,
   output logic           busy,
   output dqs_cmd_type    cmd
);

   dqs_state_type state_ff;
   dqs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.action)
               ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                  state_in = status.empty ? ST_IDLE : ST_PEEK;
               end
               ACT_SEARCH: begin
                  state_in = status.empty ? ST_IDLE : ST_SEARCH;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PEEK: begin
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (status.walk_last) begin
               state_in = ST_DRAIN_READ;
            end
         end
         ST_DRAIN_READ: begin
            state_in = ST_DRAIN_CMP;
         end
         ST_DRAIN_CMP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      cmd        = '0;
      cmd.rd_sel = RD_FRONT;
      case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         ST_EXEC: begin
            case (status.action)
               ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                  cmd.commit   = !status.full;
                  cmd.respond  = 1'b1;
                  cmd.rsp_fail = status.full;
               end
               ACT_POP_FRONT, ACT_POP_BACK: begin
                  cmd.commit   = !status.empty;
                  cmd.respond  = 1'b1;
                  cmd.rsp_fail = status.empty;
               end
               ACT_CLEAR: begin
                  cmd.commit  = 1'b1;
                  cmd.respond = 1'b1;
               end
               ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                  if (status.empty) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_fail = 1'b1;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = (status.action == ACT_PEEK_FRONT) ? RD_FRONT : RD_BACK;
                  end
               end
               default: begin
                  if (status.empty) begin
                     cmd.respond = 1'b1;
                  end else begin
                     cmd.walk_clear = 1'b1;
                  end
               end
            endcase
         end
         ST_PEEK: begin
            cmd.respond  = 1'b1;
            cmd.rsp_peek = 1'b1;
         end
         ST_SEARCH: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_WALK;
            cmd.walk_step = 1'b1;
         end
         ST_DRAIN_READ: begin
         end
         ST_DRAIN_CMP: begin
            cmd.respond   = 1'b1;
            cmd.rsp_found = 1'b1;
         end
         default: begin
         end
      endcase
   end

   `DQS_ASSERT_NEXT(a_accept_exec, clock, reset, start && !busy, state_ff == ST_EXEC)
   `DQS_ASSERT_NEXT(a_drain_respond, clock, reset, state_ff == ST_DRAIN_READ,
                    cmd.respond && cmd.rsp_found)
   `DQS_ASSERT_NOW(a_walk_reads, clock, reset, state_ff == ST_SEARCH,
                   !status.empty && cmd.rd_en)

endmodule

// ===== rtl/core/dqs_datapath.sv =====
`include "double_ended_queue_with_search_defines.svh"

module dqs_datapath
   import dqs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ACTION_WIDTH-1:0]       req_action,
   input  logic signed [VALUE_WIDTH-1:0] req_operand_value,
   input  logic                          csr_write_enable,
   input  logic [TOL_WIDTH-1:0]          csr_write_data,
   input  dqs_cmd_type                   cmd,
   output dqs_status_type                status,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic signed [VALUE_WIDTH-1:0] rsp_peeked_value,
   output logic                          rsp_found,
   output logic [COUNT_OUT_WIDTH-1:0]    rsp_entry_count,
   output logic                          rsp_is_empty
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[IDX_W-1:0];
   endfunction

   dqs_action_type                action_ff;
   logic signed [VALUE_WIDTH-1:0] operand_ff;
   logic [TOL_WIDTH-1:0]          tol_ff;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              walk_ff, walk_in;
   logic [VALUE_WIDTH-1:0]        entry_store_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0]        rd_data_ff;
   logic                          rd_valid_ff;
   logic signed [VALUE_WIDTH:0]   diff_ff, diff_in;
   logic                          diff_valid_ff;
   logic                          found_ff, found_in;

   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr, rd_addr;
   logic [IDX_W-1:0]              head_dec, head_inc, tail_free, tail_used, walk_slot;
   logic signed [VALUE_WIDTH:0]   tol_pos, tol_neg;
   logic                          hit;
   logic [CNT_W+COUNT_OUT_WIDTH-1:0] count_wide;

   logic                          rsp_strobe_ff;
   logic                          rsp_status_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_peeked_value_ff;
   logic                          rsp_found_ff;
   logic [COUNT_OUT_WIDTH-1:0]    rsp_entry_count_ff;
   logic                          rsp_is_empty_ff;

   assign head_dec  = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_inc  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_free = slot_of(head_ff, count_ff);
   assign tail_used = slot_of(head_ff, count_ff - 1'b1);
   assign walk_slot = slot_of(head_ff, CNT_W'(walk_ff));

   assign status.action    = action_ff;
   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff == CAP_CNT);
   assign status.walk_last = (CNT_W'(walk_ff) == count_ff - 1'b1);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_free;
      if (cmd.commit) begin
         case (action_ff)
            ACT_PUSH_FRONT: begin
               head_in  = head_dec;
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               count_in = count_ff + 1'b1;
            end
            ACT_PUSH_BACK: begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
            ACT_POP_FRONT: begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
            ACT_POP_BACK: begin
               count_in = count_ff - 1'b1;
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_FRONT: rd_addr = head_ff;
         RD_BACK:  rd_addr = tail_used;
         RD_WALK:  rd_addr = walk_slot;
         default:  rd_addr = head_ff;
      endcase
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_clear) begin
         walk_in = '0;
      end else if (cmd.walk_step) begin
         walk_in = walk_ff + 1'b1;
      end
   end

   assign diff_in  = $signed({rd_data_ff[VALUE_WIDTH-1], rd_data_ff})
                   - $signed({operand_ff[VALUE_WIDTH-1], operand_ff});
   assign tol_pos  = $signed({{(VALUE_WIDTH + 1 - TOL_WIDTH){1'b0}}, tol_ff});
   assign tol_neg  = -tol_pos;
   assign hit      = diff_valid_ff && (diff_ff < tol_pos) && (diff_ff > tol_neg);
   assign found_in = cmd.walk_clear ? 1'b0 : (found_ff | hit);

   assign count_wide = {{COUNT_OUT_WIDTH{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff        <= TOL_RESET;
         head_ff       <= '0;
         count_ff      <= '0;
         walk_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         diff_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
         head_ff       <= head_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         rd_valid_ff   <= cmd.rd_en && (cmd.rd_sel == RD_WALK);
         diff_valid_ff <= rd_valid_ff;
         found_ff      <= found_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff  <= dqs_action_type'(req_action);
         operand_ff <= req_operand_value;
      end
      diff_ff <= diff_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= operand_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff       <= cmd.rsp_fail;
         rsp_peeked_value_ff <= cmd.rsp_peek ? $signed(rd_data_ff) : '0;
         rsp_found_ff        <= cmd.rsp_found & (found_ff | hit);
         rsp_entry_count_ff  <= count_wide[COUNT_OUT_WIDTH-1:0];
         rsp_is_empty_ff     <= (count_in == '0);
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_peeked_value = rsp_peeked_value_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;
   assign rsp_is_empty     = rsp_is_empty_ff;

   `DQS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_CNT)
   `DQS_ASSERT_NOW(a_found_on_search, clock, reset, rsp_strobe_ff && rsp_found_ff,
                   action_ff == ACT_SEARCH)
   `DQS_ASSERT_NOW(a_peek_value, clock, reset, rsp_strobe_ff && (rsp_peeked_value_ff != '0),
                   (action_ff == ACT_PEEK_FRONT) || (action_ff == ACT_PEEK_BACK))

endmodule

// ===== rtl/core/double_ended_queue_with_search.sv =====
// Bounded double-ended queue of signed Q32.32 values in a single-port-write,
// registered-read ring memory of CAPACITY entries. A request is taken when start is
// high and busy is low; exactly one result follows on the rsp_ ports for a single
// cycle marked by rsp_strobe, and the receiver cannot stall it, so it must capture
// every strobe. Push, pop and clear pass through the EXEC state and back to IDLE,
// as do a peek or search of an empty queue, with the result registered from EXEC;
// a peek adds the PEEK state because of the registered memory read; a search adds
// SEARCH, where the one read port walks the stored entries one per cycle, then
// DRAIN_READ and DRAIN_CMP to drain the read and compare, and reports a value
// within csr tolerance (strict, exact difference). Write csr_write_data only while
// idle.
module double_ended_queue_with_search
   import dqs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ACTION_WIDTH-1:0]       req_action,
   input  logic signed [VALUE_WIDTH-1:0] req_operand_value,
   input  logic                          csr_write_enable,
   input  logic [TOL_WIDTH-1:0]          csr_write_data,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic signed [VALUE_WIDTH-1:0] rsp_peeked_value,
   output logic                          rsp_found,
   output logic [COUNT_OUT_WIDTH-1:0]    rsp_entry_count,
   output logic                          rsp_is_empty
);

   dqs_cmd_type    cmd;
   dqs_status_type status;

   dqs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   dqs_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_operand_value (req_operand_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_peeked_value  (rsp_peeked_value),
      .rsp_found         (rsp_found),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule

// ===== verif/tb_double_ended_queue_with_search.sv =====
module tb_double_ended_queue_with_search;
   timeunit 1ns;
   timeprecision 1ps;
   import dqs_pkg::*;

   localparam int DEPTH      = CAPACITY_DEFAULT;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_ITEMS = 125;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      dqs_action_type                action;
      logic signed [VALUE_WIDTH-1:0] operand;
   } deque_req_type;

   typedef struct packed {
      logic                          status;
      logic signed [VALUE_WIDTH-1:0] peeked;
      logic                          found;
      logic [COUNT_OUT_WIDTH-1:0]    count;
      logic                          empty;
   } deque_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [ACTION_WIDTH-1:0]       req_action = ACT_CLEAR;
   logic signed [VALUE_WIDTH-1:0] req_operand_value = '0;
   logic                          csr_write_enable = 1'b0;
   logic [TOL_WIDTH-1:0]          csr_write_data = '0;
   logic                          rsp_strobe;
   logic                          rsp_status;
   logic signed [VALUE_WIDTH-1:0] rsp_peeked_value;
   logic                          rsp_found;
   logic [COUNT_OUT_WIDTH-1:0]    rsp_entry_count;
   logic                          rsp_is_empty;

   deque_req_type pending_reqs[$];
   deque_rsp_type expected_rsps[$];
   deque_rsp_type next_rsp;
   int         failures = 0;
   int         quiet_cycles = 0;
   int         sender_idle_pct = 30;

   logic signed [VALUE_WIDTH-1:0] ring [DEPTH];
   logic [5:0]                    head_slot = '0;
   logic [6:0]                    entry_total = '0;
   logic [TOL_WIDTH-1:0]          tolerance = TOL_RESET;

   logic signed [VALUE_WIDTH-1:0] recent_pushes [16];
   logic [3:0]                    recent_slot = '0;

   double_ended_queue_with_search uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_operand_value (req_operand_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_peeked_value  (rsp_peeked_value),
      .rsp_found         (rsp_found),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   always #10 clock = ~clock;

   function automatic deque_rsp_type apply_request(input deque_req_type r);
      deque_rsp_type      o;
      logic [5:0]         slot;
      logic [63:0]        a;
      logic [63:0]        d;
      o = '0;
      case (r.action)
         ACT_PUSH_FRONT: begin
            if (entry_total >= DEPTH) o.status = 1'b1;
            else begin
               head_slot = head_slot - 6'd1;
               ring[head_slot] = r.operand;
               entry_total = entry_total + 7'd1;
            end
         end
         ACT_PUSH_BACK: begin
            if (entry_total >= DEPTH) o.status = 1'b1;
            else begin
               slot = head_slot + entry_total[5:0];
               ring[slot] = r.operand;
               entry_total = entry_total + 7'd1;
            end
         end
         ACT_POP_FRONT: begin
            if (entry_total == 0) o.status = 1'b1;
            else begin
               head_slot = head_slot + 6'd1;
               entry_total = entry_total - 7'd1;
            end
         end
         ACT_POP_BACK: begin
            if (entry_total == 0) o.status = 1'b1;
            else entry_total = entry_total - 7'd1;
         end
         ACT_PEEK_FRONT: begin
            if (entry_total == 0) o.status = 1'b1;
            else o.peeked = ring[head_slot];
         end
         ACT_PEEK_BACK: begin
            if (entry_total == 0) o.status = 1'b1;
            else begin
               slot = head_slot + entry_total[5:0] - 6'd1;
               o.peeked = ring[slot];
            end
         end
         ACT_CLEAR: begin
            entry_total = '0;
         end
         default: begin
            for (int i = 0; i < entry_total; i++) begin
               slot = head_slot + i[5:0];
               a = ring[slot];
               if ($signed(a) >= $signed(r.operand)) d = a - r.operand;
               else d = r.operand - a;
               if (d < {32'd0, tolerance}) o.found = 1'b1;
            end
         end
      endcase
      o.count = entry_total;
      o.empty = (entry_total == 0);
      return o;
   endfunction

   task automatic queue_req(input dqs_action_type act,
                            input logic signed [VALUE_WIDTH-1:0] val);
      deque_req_type r;
      r.action  = act;
      r.operand = val;
      pending_reqs.push_back(r);
      if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
         recent_pushes[recent_slot] = val;
         recent_slot = recent_slot + 4'd1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
      failures++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || start || busy);
      repeat (4) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
         if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
            start             <= 1'b1;
            req_action        <= pending_reqs[0].action;
            req_operand_value <= pending_reqs[0].operand;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_entry_count), 64'd0);
         end else begin
            next_rsp = expected_rsps.pop_front();
            if (rsp_status !== next_rsp.status)
               report_mismatch("status", 64'(rsp_status), 64'(next_rsp.status));
            if (rsp_peeked_value !== next_rsp.peeked)
               report_mismatch("peeked_value", rsp_peeked_value, next_rsp.peeked);
            if (rsp_found !== next_rsp.found)
               report_mismatch("found", 64'(rsp_found), 64'(next_rsp.found));
            if (rsp_entry_count !== next_rsp.count)
               report_mismatch("entry_count", 64'(rsp_entry_count), 64'(next_rsp.count));
            if (rsp_is_empty !== next_rsp.empty)
               report_mismatch("is_empty", 64'(rsp_is_empty), 64'(next_rsp.empty));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int                            n;
      int                            len;
      int                            burst;
      int                            pick;
      dqs_action_type                act;
      logic signed [VALUE_WIDTH-1:0] val;
      logic [63:0]                   span;
      logic [TOL_WIDTH-1:0]          next_tol;

      for (int i = 0; i < 16; i++) recent_pushes[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue, extremes, both ends, search edges of the default window
      queue_req(ACT_POP_FRONT, 64'sd0);
      queue_req(ACT_POP_BACK, 64'sd0);
      queue_req(ACT_PEEK_FRONT, 64'sd0);
      queue_req(ACT_PEEK_BACK, 64'sd0);
      queue_req(ACT_SEARCH, 64'sd0);
      queue_req(ACT_PUSH_BACK, VAL_MAX);
      queue_req(ACT_PUSH_FRONT, VAL_MIN);
      queue_req(ACT_PUSH_BACK, 64'sd0);
      queue_req(ACT_PUSH_FRONT, -64'sd1);
      queue_req(ACT_PEEK_FRONT, 64'sd0);
      queue_req(ACT_PEEK_BACK, 64'sd0);
      queue_req(ACT_SEARCH, VAL_MAX);
      queue_req(ACT_SEARCH, VAL_MAX - 64'sd4096);
      queue_req(ACT_SEARCH, VAL_MIN + 64'sd4095);
      queue_req(ACT_SEARCH, 64'sh0000_0001_0000_0000);
      queue_req(ACT_POP_FRONT, 64'sd0);
      queue_req(ACT_PEEK_FRONT, 64'sd0);
      queue_req(ACT_POP_BACK, 64'sd0);
      queue_req(ACT_PEEK_BACK, 64'sd0);
      queue_req(ACT_CLEAR, 64'sd0);
      queue_req(ACT_PEEK_FRONT, 64'sd0);
      queue_req(ACT_CLEAR, 64'sd0);
      queue_req(ACT_SEARCH, 64'sd0);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       next_tol = 32'hFFFF_FFFF;
            1:       next_tol = 32'd0;
            2:       next_tol = 32'd1;
            3:       next_tol = $urandom;
            4:       next_tol = 32'h0010_0000;
            default: next_tol = $urandom_range(65535, 0);
         endcase
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data   <= next_tol;
         tolerance = next_tol;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         @(negedge clock);
         sender_idle_pct = (p < 2) ? 30 : (p < 4) ? 63 : 0;

         n = 0;
         while (n < PHASE_ITEMS) begin
            burst = $urandom_range(9, 0);
            if (burst < 2) len = $urandom_range(72, 30);
            else if (burst == 2) len = 1;
            else len = $urandom_range(8, 1);
            for (int j = 0; j < len && n < PHASE_ITEMS; j++) begin
               case (burst)
                  0:       act = dqs_action_type'($urandom_range(1, 0));
                  1:       act = dqs_action_type'($urandom_range(5, 2));
                  2:       act = ACT_CLEAR;
                  3, 4:    act = ACT_SEARCH;
                  default: act = dqs_action_type'($urandom_range(7, 0));
               endcase
               pick = $urandom_range(3, 0);
               if (act == ACT_SEARCH && pick != 0) begin
                  span = {31'd0, tolerance, 1'b0} + 64'd1;
                  val  = recent_pushes[$urandom_range(15, 0)]
                         + ({$urandom, $urandom} % span) - {32'd0, tolerance};
               end else if (pick == 0) begin
                  case ($urandom_range(4, 0))
                     0:       val = VAL_MAX;
                     1:       val = VAL_MIN;
                     2:       val = 64'sd0;
                     3:       val = -64'sd1;
                     default: val = 64'sd1;
                  endcase
               end else begin
                  val = {$urandom, $urandom};
               end
               queue_req(act, val);
               n++;
            end
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dqs_pkg.sv
rtl/core/dqs_ctrl.sv
rtl/core/dqs_datapath.sv
rtl/core/double_ended_queue_with_search.sv
verif/tb_double_ended_queue_with_search.sv
